### hw/rtl/rbpp_pkg.sv
// shared types, constants and root table for the rank biased parent picker
package rbpp_pkg;

   localparam int MAX_FRONTS     = 256;
   localparam int MAX_FRONT_SIZE = 4096;
   localparam int FRAC_BITS      = 16;

   typedef enum logic [0:0] {
      CMD_LOAD   = 1'b0,
      CMD_SELECT = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic [7:0]  front_index;
      logic [12:0] front_size;
      logic [8:0]  front_count;
      logic [31:0] draw_front_first;
      logic [31:0] draw_front_second;
      logic [31:0] draw_member_first;
      logic [31:0] draw_member_second;
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NORM,
      ST_SQR,
      ST_LOG,
      ST_EXP,
      ST_SCALE,
      ST_FRONT,
      ST_READ,
      ST_MEMBER
   } engine_state_type;

   function automatic logic [63:0] isqrt64(logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^(-2^-(k+1)) in q0.32, truncated square root chain
   function automatic logic [31:0] root_value(int k);
      logic [63:0] c;
      c = 64'h0000_0000_8000_0000;
      for (int j = 0; j <= k; j++) begin
         c = isqrt64(c << 32);
      end
      return c[31:0];
   endfunction

   localparam logic [31:0] ROOT_TABLE [FRAC_BITS] = '{
      root_value(0),  root_value(1),  root_value(2),  root_value(3),
      root_value(4),  root_value(5),  root_value(6),  root_value(7),
      root_value(8),  root_value(9),  root_value(10), root_value(11),
      root_value(12), root_value(13), root_value(14), root_value(15)
   };

endpackage

### hw/rtl/rbpp_front.sv
// input side: accepts items, classifies and saturates them, queues them
module rbpp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [159:0]      req_tdata,
   input  logic              req_tuser,
   output logic              q_valid,
   output rbpp_pkg::job_type q_item,
   input  logic              q_pop
);

   rbpp_pkg::job_type queue_ff [2];
   rbpp_pkg::job_type job_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;
   logic [12:0] size_raw;
   logic [8:0]  count_raw;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign pop        = q_pop && q_valid;
   assign q_item     = queue_ff[rd_ptr_ff];

   assign size_raw  = req_tdata[20:8];
   assign count_raw = req_tdata[29:21];

   always_comb begin
      job_in.command            = rbpp_pkg::command_type'(req_tuser);
      job_in.front_index        = req_tdata[7:0];
      job_in.front_size         = (size_raw > 13'(rbpp_pkg::MAX_FRONT_SIZE)) ?
                                  13'(rbpp_pkg::MAX_FRONT_SIZE) : size_raw;
      if (count_raw == 9'd0) begin
         job_in.front_count = 9'd1;
      end else if (count_raw > 9'(rbpp_pkg::MAX_FRONTS)) begin
         job_in.front_count = 9'(rbpp_pkg::MAX_FRONTS);
      end else begin
         job_in.front_count = count_raw;
      end
      job_in.draw_front_first   = req_tdata[61:30];
      job_in.draw_front_second  = req_tdata[93:62];
      job_in.draw_member_first  = req_tdata[125:94];
      job_in.draw_member_second = req_tdata[157:126];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

### hw/rtl/rbpp_engine.sv
// back side: size table, power evaluation on a shared multiplier, result register
module rbpp_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic [16:0]       bias_exponent,
   input  logic              q_valid,
   input  rbpp_pkg::job_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);

   rbpp_pkg::engine_state_type state_ff, state_in;
   logic        parent_ff, parent_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [31:0] m_ff, m_in;
   logic [4:0]  msb_ff, msb_in;
   logic [15:0] frac_ff, frac_in;
   logic [22:0] t_ff, t_in;
   logic [31:0] p_ff, p_in;
   logic        p_one_ff, p_one_in;
   logic [32:0] pfull_ff, pfull_in;
   rbpp_pkg::job_type job_ff, job_in;
   logic [7:0]  front0_ff, front0_in, front1_ff, front1_in;
   logic [11:0] member0_ff, member0_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic [12:0] rdata_ff;
   logic [12:0] table_mem [rbpp_pkg::MAX_FRONTS];
   logic        mem_we;
   logic [7:0]  rd_addr;

   logic [32:0] mul_a;
   logic [31:0] mul_b;
   logic [64:0] prod;
   logic [32:0] sq;
   logic [21:0] lg;
   logic [32:0] y;
   logic [9:0]  fidx;
   logic [12:0] midx;
   logic [11:0] member;
   logic        slot_free;

   assign prod       = mul_a * mul_b;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rd_addr    = parent_ff ? front1_ff : front0_ff;
   assign sq         = prod[63:31];
   assign lg         = 22'(32 << rbpp_pkg::FRAC_BITS) - {1'b0, msb_ff, frac_ff};
   assign y          = 33'h1_0000_0000 - pfull_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         rbpp_pkg::ST_SQR: begin
            mul_a = {1'b0, m_ff};
            mul_b = m_ff;
         end
         rbpp_pkg::ST_LOG: begin
            mul_a = 33'(lg);
            mul_b = 32'(bias_exponent);
         end
         rbpp_pkg::ST_EXP: begin
            mul_a = {1'b0, p_ff};
            mul_b = rbpp_pkg::ROOT_TABLE[~cnt_ff];
         end
         rbpp_pkg::ST_FRONT: begin
            mul_a = y;
            mul_b = 32'(job_ff.front_count);
         end
         rbpp_pkg::ST_MEMBER: begin
            mul_a = parent_ff ? {1'b0, job_ff.draw_member_second}
                              : {1'b0, job_ff.draw_member_first};
            mul_b = 32'(rdata_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fidx = prod[41:32];
      if (fidx >= 10'(job_ff.front_count)) begin
         fidx = 10'(job_ff.front_count) - 10'd1;
      end
      midx = prod[44:32];
      if (rdata_ff <= 13'd1) begin
         member = '0;
      end else if (midx >= rdata_ff) begin
         member = 12'(rdata_ff - 13'd1);
      end else begin
         member = midx[11:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      parent_in    = parent_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      msb_in       = msb_ff;
      frac_in      = frac_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      p_one_in     = p_one_ff;
      pfull_in     = pfull_ff;
      job_in       = job_ff;
      front0_in    = front0_ff;
      front1_in    = front1_ff;
      member0_in   = member0_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      unique case (state_ff)
         rbpp_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.command == rbpp_pkg::CMD_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  job_in    = q_item;
                  parent_in = 1'b0;
                  m_in      = q_item.draw_front_first;
                  msb_in    = 5'd31;
                  state_in  = rbpp_pkg::ST_NORM;
               end
            end
         end
         rbpp_pkg::ST_NORM: begin
            if (m_ff == 32'd0) begin
               pfull_in = '0;
               state_in = rbpp_pkg::ST_FRONT;
            end else if (m_ff[31:24] == 8'd0) begin
               m_in   = m_ff << 8;
               msb_in = msb_ff - 5'd8;
            end else if (!m_ff[31]) begin
               m_in   = m_ff << 1;
               msb_in = msb_ff - 5'd1;
            end else begin
               cnt_in   = '0;
               frac_in  = '0;
               state_in = rbpp_pkg::ST_SQR;
            end
         end
         rbpp_pkg::ST_SQR: begin
            if (sq[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sq[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sq[31:0];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = rbpp_pkg::ST_LOG;
            end
         end
         rbpp_pkg::ST_LOG: begin
            t_in     = prod[38:16];
            p_in     = '0;
            p_one_in = 1'b1;
            cnt_in   = '0;
            state_in = rbpp_pkg::ST_EXP;
         end
         rbpp_pkg::ST_EXP: begin
            if (t_ff[cnt_ff]) begin
               p_one_in = 1'b0;
               p_in     = p_one_ff ? rbpp_pkg::ROOT_TABLE[~cnt_ff] : prod[63:32];
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = rbpp_pkg::ST_SCALE;
            end
         end
         rbpp_pkg::ST_SCALE: begin
            pfull_in = t_ff[22] ? 33'd0 : ({p_one_ff, p_ff} >> t_ff[21:16]);
            state_in = rbpp_pkg::ST_FRONT;
         end
         rbpp_pkg::ST_FRONT: begin
            if (parent_ff) begin
               front1_in = fidx[7:0];
            end else begin
               front0_in = fidx[7:0];
            end
            state_in = rbpp_pkg::ST_READ;
         end
         rbpp_pkg::ST_READ: begin
            state_in = rbpp_pkg::ST_MEMBER;
         end
         rbpp_pkg::ST_MEMBER: begin
            if (parent_ff) begin
               // hold here until the result register can take the pair
               if (slot_free) begin
                  rsp_data_in  = {member, front1_ff, member0_ff, front0_ff};
                  rsp_valid_in = 1'b1;
                  state_in     = rbpp_pkg::ST_IDLE;
               end
            end else begin
               member0_in = member;
               parent_in  = 1'b1;
               m_in       = job_ff.draw_front_second;
               msb_in     = 5'd31;
               state_in   = rbpp_pkg::ST_NORM;
            end
         end
         default: begin
            state_in = rbpp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbpp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      parent_ff   <= parent_in;
      cnt_ff      <= cnt_in;
      m_ff        <= m_in;
      msb_ff      <= msb_in;
      frac_ff     <= frac_in;
      t_ff        <= t_in;
      p_ff        <= p_in;
      p_one_ff    <= p_one_in;
      pfull_ff    <= pfull_in;
      job_ff      <= job_in;
      front0_ff   <= front0_in;
      front1_ff   <= front1_in;
      member0_ff  <= member0_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[q_item.front_index] <= q_item.front_size;
      end
      rdata_ff <= table_mem[rd_addr];
   end

endmodule

### hw/rtl/rank_biased_parent_picker.sv
// top level of the rank biased parent picker
// A load item writes the size table. A select item uses the shared 33x32
// multiplier for 16 log squarings and 16 exponent root steps per parent, after
// the normalize steps and before the table read; a zero front draw skips the
// squarings and root steps. The last step of a select holds until the result
// register is free. A two-entry queue sits between the input side and the back
// end, and the result register lets the next item start while a result waits
// to be taken.
module rank_biased_parent_picker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // front_index, front_size, front_count, draw_front_first, draw_front_second,
   // draw_member_first, draw_member_second, zero pad
   input  logic [159:0] req_tdata,
   // command
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // first_front, first_member, second_front, second_member
   output logic [39:0]  rsp_tdata,
   input  logic         csr_wen,
   input  logic [16:0]  csr_wdata
);

   logic [16:0]       bias_exponent_ff;
   logic              q_valid;
   logic              q_pop;
   rbpp_pkg::job_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_exponent_ff <= 17'h1_0000;
      end else if (csr_wen) begin
         bias_exponent_ff <= csr_wdata;
      end
   end

   rbpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   rbpp_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .bias_exponent (bias_exponent_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

### sim/testbench.sv
// testbench for the rank biased parent picker: random and directed items, bit-true predictor
`timescale 1ns / 100ps

module testbench;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_wen = 1'b0;
   logic [16:0]  csr_wdata = '0;

   typedef struct packed {
      logic [7:0]  first_front;
      logic [11:0] first_member;
      logic [7:0]  second_front;
      logic [11:0] second_member;
   } pair_type;

   rank_biased_parent_picker uut (.*);

   always #2 clock = ~clock;

   rbpp_pkg::job_type pending_jobs[$];
   pair_type          expected_pairs[$];
   logic [12:0]       sizes[rbpp_pkg::MAX_FRONTS];
   logic [31:0]       roots[rbpp_pkg::FRAC_BITS];
   logic [16:0]       exponent;
   int                errors = 0;
   int                send_gap = 0;
   int                take_gap = 0;

   function automatic logic [63:0] square_root(logic [63:0] v_in);
      logic [63:0] v, r, b;
      v = v_in;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v && b != 0) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] raise_fraction(logic [31:0] x, logic [16:0] e);
      logic [63:0] m, lg, t, p;
      logic [15:0] frac;
      int          msb;
      frac = '0;
      msb = 31;
      if (x == 0) return 64'd0;
      while (x[msb] == 1'b0) msb--;
      m = 64'(x) << (31 - msb);
      for (int i = 0; i < rbpp_pkg::FRAC_BITS; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      lg = (64'd32 << 16) - ((64'(msb) << 16) | 64'(frac));
      t = (lg * 64'(e)) >> 16;
      p = 64'h1_0000_0000;
      for (int i = 0; i < rbpp_pkg::FRAC_BITS; i++)
         if (t[i]) p = (p * 64'(roots[rbpp_pkg::FRAC_BITS - 1 - i])) >> 32;
      if ((t >> 16) >= 64) return 64'd0;
      return p >> (t >> 16);
   endfunction

   function automatic logic [7:0] front_of(logic [31:0] x, int count);
      logic [63:0] idx;
      idx = ((64'h1_0000_0000 - raise_fraction(x, exponent)) * 64'(count)) >> 32;
      if (idx >= count) idx = count - 1;
      return idx[7:0];
   endfunction

   function automatic logic [11:0] member_of(logic [7:0] front, logic [31:0] u);
      logic [63:0] size, idx;
      size = 64'(sizes[front]);
      if (size <= 1) return 12'd0;
      idx = (64'(u) * size) >> 32;
      if (idx >= size) idx = size - 1;
      return idx[11:0];
   endfunction

   task automatic predict_job(rbpp_pkg::job_type j);
      pair_type pr;
      int       count;
      if (j.command == rbpp_pkg::CMD_LOAD) begin
         sizes[j.front_index] = (j.front_size > rbpp_pkg::MAX_FRONT_SIZE) ?
                                13'(rbpp_pkg::MAX_FRONT_SIZE) : j.front_size;
         return;
      end
      count = j.front_count;
      if (count == 0) count = 1;
      if (count > rbpp_pkg::MAX_FRONTS) count = rbpp_pkg::MAX_FRONTS;
      pr.first_front = front_of(j.draw_front_first, count);
      pr.second_front = front_of(j.draw_front_second, count);
      pr.first_member = member_of(pr.first_front, j.draw_member_first);
      pr.second_member = member_of(pr.second_front, j.draw_member_second);
      expected_pairs.push_back(pr);
   endtask

   function automatic rbpp_pkg::job_type load_job(int idx, int size);
      rbpp_pkg::job_type j;
      j = '0;
      j.command = rbpp_pkg::CMD_LOAD;
      j.front_index = idx[7:0];
      j.front_size = size[12:0];
      return j;
   endfunction

   function automatic rbpp_pkg::job_type select_job(int count, logic [31:0] a,
                                                    logic [31:0] b, logic [31:0] c,
                                                    logic [31:0] d);
      rbpp_pkg::job_type j;
      j.command = rbpp_pkg::CMD_SELECT;
      j.front_index = 8'($urandom);
      j.front_size = 13'($urandom);
      j.front_count = count[8:0];
      j.draw_front_first = a;
      j.draw_front_second = b;
      j.draw_member_first = c;
      j.draw_member_second = d;
      return j;
   endfunction

   function automatic logic [31:0] random_draw();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 255);
         3: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_jobs.size() > 0) begin
            rbpp_pkg::job_type j;
            j = pending_jobs.pop_front();
            predict_job(j);
            req_tvalid <= 1'b1;
            req_tuser <= j.command;
            req_tdata <= {2'd0, j.draw_member_second, j.draw_member_first,
                          j.draw_front_second, j.draw_front_first, j.front_count,
                          j.front_size, j.front_index};
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            pair_type got, want;
            got = '{first_front: rsp_tdata[7:0], first_member: rsp_tdata[19:8],
                    second_front: rsp_tdata[27:20], second_member: rsp_tdata[39:28]};
            if (expected_pairs.size() == 0) begin
               $display("%0t unexpected item: expected none, actual %h", $time, got);
               errors++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.first_front !== want.first_front) begin
                  $display("%0t first_front: expected %0d, actual %0d", $time,
                           want.first_front, got.first_front);
                  errors++;
               end
               if (got.first_member !== want.first_member) begin
                  $display("%0t first_member: expected %0d, actual %0d", $time,
                           want.first_member, got.first_member);
                  errors++;
               end
               if (got.second_front !== want.second_front) begin
                  $display("%0t second_front: expected %0d, actual %0d", $time,
                           want.second_front, got.second_front);
                  errors++;
               end
               if (got.second_member !== want.second_member) begin
                  $display("%0t second_member: expected %0d, actual %0d", $time,
                           want.second_member, got.second_member);
                  errors++;
               end
            end
         end
         if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               take_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         end
      end
   end

   task automatic wait_drained();
      while (pending_jobs.size() > 0 || req_tvalid || expected_pairs.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_exponent(logic [16:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      exponent = value;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic load_all_fronts(bit full);
      for (int i = 0; i < rbpp_pkg::MAX_FRONTS; i++)
         pending_jobs.push_back(load_job(i, full ? $urandom_range(0, 8191)
                                                 : $urandom_range(0, 40)));
   endtask

   initial begin
      logic [16:0] settings[6];
      settings = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd21845, 17'd40000};
      roots[0] = 32'(square_root(64'h8000_0000 << 32));
      for (int k = 1; k < rbpp_pkg::FRAC_BITS; k++)
         roots[k] = 32'(square_root(64'(roots[k - 1]) << 32));
      exponent = 17'd65536;
      for (int i = 0; i < rbpp_pkg::MAX_FRONTS; i++) sizes[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes of the table and the draws
      load_all_fronts(1'b0);
      pending_jobs.push_back(load_job(0, 4096));
      pending_jobs.push_back(load_job(1, 8191));
      pending_jobs.push_back(load_job(255, 0));
      pending_jobs.push_back(load_job(2, 1));
      pending_jobs.push_back(load_job(3, 4097));
      pending_jobs.push_back(select_job(0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0));
      pending_jobs.push_back(select_job(1, 32'd1, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_jobs.push_back(select_job(256, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF));
      pending_jobs.push_back(select_job(511, 32'd1, 32'h8000_0000, 32'h8000_0000, 32'd1));
      pending_jobs.push_back(select_job(257, 32'hFFFF_FFFE, 32'h0000_0100,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_jobs.push_back(select_job(4, 32'h4000_0000, 32'hC000_0000, 32'hAAAA_AAAA,
                                        32'h5555_5555));
      wait_drained();

      foreach (settings[s]) begin
         write_exponent(settings[s]);
         if (s == 3) load_all_fronts(1'b1);
         for (int n = 0; n < 240; n++) begin
            if ($urandom_range(0, 9) == 0)
               pending_jobs.push_back(load_job($urandom_range(0, 255),
                                               $urandom_range(0, 8191)));
            else
               pending_jobs.push_back(select_job(
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, 256),
                  random_draw(), random_draw(), random_draw(), random_draw()));
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
